[sv/lfc_pkg.sv]
// ----------------------------------------------------------------------------
// lfc_pkg
// Shared types and constants for the length-prefixed frame checker.
// ----------------------------------------------------------------------------
package lfc_pkg;

    localparam int unsigned LFC_POSITION_BITS = 32;
    localparam logic [31:0] LFC_MAGIC_RESET   = 32'h5646_4C58;
    localparam logic [15:0] LFC_HDR_BYTES     = 16'd9;
    localparam logic [7:0]  LFC_ASCII_MAX     = 8'h7F;
    localparam int unsigned LFC_Q_DEPTH       = 4;

    typedef enum logic [1:0] {
        PH_MAGIC,
        PH_LEN,
        PH_BODY,
        PH_DRAIN
    } t_phase;

    // What the front end decided; the back end turns it into a record
    typedef enum logic [1:0] {
        K_MAGIC,
        K_TRUNC_LEN,
        K_TRUNC_FRAME,
        K_FRAME
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_MAGIC   = 3'd1,
        ST_TRUNC_LEN   = 3'd2,
        ST_TRUNC_FRAME = 3'd3,
        ST_BAD_HDR     = 3'd4,
        ST_NON_ASCII   = 3'd5,
        ST_EMPTY       = 3'd6
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] offset;
        logic [63:0] seq;
        logic [7:0]  slen;
        logic [15:0] flen;
        logic        hdr_bad;
        logic        ascii;
    } t_rec;

endpackage

[sv/lfc_if.sv]
// ----------------------------------------------------------------------------
// lfc_if
// Valid/ready channels for the byte stream in and the frame records out.
// ----------------------------------------------------------------------------
interface lfc_in_if;
    logic       valid;
    logic       ready;
    logic       has_byte;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, has_byte, data_byte, stream_end, input ready);
    modport sink   (input valid, has_byte, data_byte, stream_end, output ready);
endinterface

interface lfc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] frame_offset;
    logic        has_sequence;
    logic [63:0] seq_number;
    logic        has_session;
    logic [7:0]  session_length;
    logic [15:0] frame_length;
    logic [15:0] payload_length;

    modport source (output valid, status, frame_offset, has_sequence, seq_number,
                    has_session, session_length, frame_length, payload_length,
                    input ready);
    modport sink   (input valid, status, frame_offset, has_sequence, seq_number,
                    has_session, session_length, frame_length, payload_length,
                    output ready);
endinterface

[sv/lfc_fifo.sv]
// ----------------------------------------------------------------------------
// lfc_fifo
// Short register queue of decision records between front and back end.
// ----------------------------------------------------------------------------
module lfc_fifo #(
    parameter int unsigned DEPTH = lfc_pkg::LFC_Q_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  lfc_pkg::t_rec i_data,
    output logic         o_full,
    output logic         o_valid,
    input  logic         i_pop,
    output lfc_pkg::t_rec o_data
);
    import lfc_pkg::*;

    localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST = PTR_BITS'(DEPTH - 1);

    t_rec                r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == CNT_BITS'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[sv/lfc_front.sv]
// ----------------------------------------------------------------------------
// lfc_front
// Byte parser: magic check, length and header capture, frame decisions.
// ----------------------------------------------------------------------------
module lfc_front #(
    parameter int unsigned POSITION_BITS = lfc_pkg::LFC_POSITION_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [31:0]   i_cfg_wr_data,
    lfc_in_if.sink        i_in,
    input  logic          i_q_full,
    output logic          o_push,
    output lfc_pkg::t_rec o_rec
);
    import lfc_pkg::*;

    logic [31:0]              r_magic;
    t_phase                   r_phase,   n_phase;
    logic [15:0]              r_cnt,     n_cnt;
    logic [POSITION_BITS-1:0] r_pos,     n_pos;
    logic [POSITION_BITS-1:0] r_start,   n_start;
    logic [15:0]              r_len,     n_len;
    logic [63:0]              r_seq,     n_seq;
    logic [7:0]               r_slen,    n_slen;
    logic                     r_ascii,   n_ascii;
    logic                     r_hb,      n_hb;

    logic       acc;
    logic [7:0] b;
    logic [7:0] expect_byte;

    function automatic t_rec mk_rec(t_kind k, logic [POSITION_BITS-1:0] start,
                                    logic [63:0] seq, logic [7:0] slen,
                                    logic [15:0] flen, logic hb, logic ascii);
        t_rec r;
        r.kind    = k;
        r.offset  = 32'(64'(start));
        r.seq     = seq;
        r.slen    = slen;
        r.flen    = flen;
        r.hdr_bad = hb;
        r.ascii   = ascii;
        return r;
    endfunction

    assign i_in.ready = !i_q_full;
    assign acc        = i_in.valid && i_in.ready;
    assign b          = i_in.data_byte;

    always_comb begin
        unique case (r_cnt[1:0])
            2'd0:    expect_byte = r_magic[31:24];
            2'd1:    expect_byte = r_magic[23:16];
            2'd2:    expect_byte = r_magic[15:8];
            default: expect_byte = r_magic[7:0];
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_pos   = r_pos;
        n_start = r_start;
        n_len   = r_len;
        n_seq   = r_seq;
        n_slen  = r_slen;
        n_ascii = r_ascii;
        n_hb    = r_hb;
        o_push  = 1'b0;
        o_rec   = '0;

        if (acc && i_in.has_byte) begin
            unique case (r_phase)
                PH_MAGIC: begin
                    if (b != expect_byte) begin
                        o_push  = 1'b1;
                        o_rec   = mk_rec(K_MAGIC, '0, '0, '0, '0, 1'b0, 1'b0);
                        n_phase = PH_DRAIN;
                    end else if (r_cnt[1:0] == 2'd3) begin
                        n_phase = PH_LEN;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = r_cnt + 16'd1;
                    end
                end
                PH_LEN: begin
                    if (r_cnt == '0) begin
                        n_start = r_pos;
                        n_len   = {8'd0, b};
                        n_cnt   = 16'd1;
                    end else begin
                        n_len = {r_len[7:0], b};
                        n_cnt = '0;
                        if (n_len < LFC_HDR_BYTES) begin
                            o_push  = 1'b1;
                            o_rec   = mk_rec(K_TRUNC_FRAME, r_start, '0, '0, n_len,
                                             1'b0, 1'b0);
                            n_phase = PH_DRAIN;
                        end else begin
                            n_phase = PH_BODY;
                            n_seq   = '0;
                            n_slen  = '0;
                            n_ascii = 1'b1;
                            n_hb    = 1'b0;
                        end
                    end
                end
                PH_BODY: begin
                    if (r_cnt < 16'd8) begin
                        n_seq = {r_seq[55:0], b};
                    end else if (r_cnt == 16'd8) begin
                        n_slen = b;
                        // session must fit inside the frame body
                        n_hb   = (r_seq == '0) || (b == '0) ||
                                 ((17'(LFC_HDR_BYTES) + 17'(b)) > 17'(r_len));
                    end else if ((r_cnt < (LFC_HDR_BYTES + 16'(r_slen))) &&
                                 (b > LFC_ASCII_MAX)) begin
                        n_ascii = 1'b0;
                    end
                    n_cnt = r_cnt + 16'd1;
                    if (n_cnt >= r_len) begin
                        o_push  = 1'b1;
                        o_rec   = mk_rec(K_FRAME, r_start, n_seq, n_slen, r_len,
                                         n_hb, n_ascii);
                        n_phase = PH_LEN;
                        n_cnt   = '0;
                        n_len   = '0;
                    end
                end
                default: begin
                end
            endcase
            n_pos = r_pos + 1'b1;
        end

        if (acc && i_in.stream_end) begin
            if (!o_push) begin
                if (n_phase == PH_MAGIC) begin
                    o_push = 1'b1;
                    o_rec  = mk_rec(K_MAGIC, '0, '0, '0, '0, 1'b0, 1'b0);
                end else if (n_phase == PH_LEN && n_cnt == 16'd1) begin
                    o_push = 1'b1;
                    o_rec  = mk_rec(K_TRUNC_LEN, n_start, '0, '0, '0, 1'b0, 1'b0);
                end else if (n_phase == PH_BODY) begin
                    o_push = 1'b1;
                    o_rec  = mk_rec(K_TRUNC_FRAME, n_start, '0, '0, n_len, 1'b0, 1'b0);
                end
            end
            n_phase = PH_MAGIC;
            n_cnt   = '0;
            n_pos   = '0;
            n_start = '0;
            n_len   = '0;
            n_seq   = '0;
            n_slen  = '0;
            n_ascii = 1'b1;
            n_hb    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= LFC_MAGIC_RESET;
            r_phase <= PH_MAGIC;
            r_cnt   <= '0;
            r_pos   <= '0;
            r_start <= '0;
            r_len   <= '0;
            r_seq   <= '0;
            r_slen  <= '0;
            r_ascii <= 1'b1;
            r_hb    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_magic <= i_cfg_wr_data;
            end
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_len   <= n_len;
            r_seq   <= n_seq;
            r_slen  <= n_slen;
            r_ascii <= n_ascii;
            r_hb    <= n_hb;
        end
    end

endmodule

[sv/lfc_back.sv]
// ----------------------------------------------------------------------------
// lfc_back
// Turns queued decisions into result records; holds the output register.
// ----------------------------------------------------------------------------
module lfc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  lfc_pkg::t_rec i_rec,
    output logic          o_pop,
    lfc_out_if.source     o_out
);
    import lfc_pkg::*;

    logic        r_valid;
    logic [2:0]  r_status,  n_status;
    logic [31:0] r_offset,  n_offset;
    logic        r_hseq,    n_hseq;
    logic [63:0] r_seq,     n_seq;
    logic        r_hses,    n_hses;
    logic [7:0]  r_slen,    n_slen;
    logic [15:0] r_flen,    n_flen;
    logic [15:0] r_plen,    n_plen;
    logic [15:0] payload;

    assign o_pop   = i_q_valid && (!r_valid || o_out.ready);
    assign payload = i_rec.flen - LFC_HDR_BYTES - 16'(i_rec.slen);

    always_comb begin
        n_status = ST_BAD_MAGIC;
        n_offset = '0;
        n_hseq   = 1'b0;
        n_seq    = '0;
        n_hses   = 1'b0;
        n_slen   = '0;
        n_flen   = '0;
        n_plen   = '0;
        unique case (i_rec.kind)
            K_MAGIC: begin
                n_status = ST_BAD_MAGIC;
            end
            K_TRUNC_LEN: begin
                n_status = ST_TRUNC_LEN;
                n_offset = i_rec.offset;
            end
            K_TRUNC_FRAME: begin
                n_status = ST_TRUNC_FRAME;
                n_offset = i_rec.offset;
                n_flen   = i_rec.flen;
            end
            default: begin
                n_offset = i_rec.offset;
                n_hseq   = 1'b1;
                n_seq    = i_rec.seq;
                n_slen   = i_rec.slen;
                n_flen   = i_rec.flen;
                priority if (i_rec.hdr_bad) begin
                    n_status = ST_BAD_HDR;
                end else if (!i_rec.ascii) begin
                    n_status = ST_NON_ASCII;
                end else begin
                    n_status = (payload == '0) ? ST_EMPTY : ST_OK;
                    n_hses   = 1'b1;
                    n_plen   = payload;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status <= n_status;
            r_offset <= n_offset;
            r_hseq   <= n_hseq;
            r_seq    <= n_seq;
            r_hses   <= n_hses;
            r_slen   <= n_slen;
            r_flen   <= n_flen;
            r_plen   <= n_plen;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.status         = r_status;
    assign o_out.frame_offset   = r_offset;
    assign o_out.has_sequence   = r_hseq;
    assign o_out.seq_number     = r_seq;
    assign o_out.has_session    = r_hses;
    assign o_out.session_length = r_slen;
    assign o_out.frame_length   = r_flen;
    assign o_out.payload_length = r_plen;

endmodule

[sv/length_prefixed_frame_checker.sv]
// ----------------------------------------------------------------------------
// length_prefixed_frame_checker
// Checks a magic-prefixed stream of length-prefixed frames, one byte per item.
// ----------------------------------------------------------------------------
// Throughput: one byte item per cycle; input stalls only when the 4-entry
//   record queue between parser and formatter is full.
// Record path: the edge that accepts the deciding item writes the queue; the
//   output register takes it once that register is empty or being read.
// Reset: synchronous; magic word back to 0x56464C58, parser returns to the
//   magic check, queue and output emptied.
module length_prefixed_frame_checker #(
    parameter int unsigned POSITION_BITS = lfc_pkg::LFC_POSITION_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    lfc_in_if.sink      i_in,
    lfc_out_if.source   o_out
);
    import lfc_pkg::*;

    logic q_push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    t_rec q_wr_rec;
    t_rec q_rd_rec;

    lfc_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (i_in),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_rec         (q_wr_rec)
    );

    lfc_fifo #(
        .DEPTH (LFC_Q_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_rec),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_rd_rec)
    );

    lfc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_rec     (q_rd_rec),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

    // a decision must never be dropped at a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full))
        else $error("record pushed into full queue");

    a_session_has_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.has_session) |-> o_out.has_sequence)
        else $error("session flagged without sequence");

    a_magic_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_BAD_MAGIC) |->
            (o_out.frame_offset == '0 && !o_out.has_sequence))
        else $error("bad magic record carries frame data");

    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> o_out.valid)
        else $error("popped record not presented");

endmodule
